[rtl/csu_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and controller/datapath interface types for the cosine similarity unit.
package csu_pkg;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int SQ_W       = 2 * ELEM_W - 1;
  localparam int DOT_W      = 42;
  localparam int NORM_W     = 41;
  localparam int EPS_W      = 16;
  localparam int ROOT_W     = (NORM_W + 1) / 2;
  localparam int RPROD_W    = 2 * ROOT_W;
  localparam int DEN_W      = RPROD_W + 1;
  localparam int T_W        = DEN_W + 1;
  localparam int SIM_W      = 16;
  localparam int QUO_W      = SIM_W + 1;
  localparam int DSH_W      = DEN_W + SIM_W;
  localparam int NUM_W      = DSH_W + 1;
  localparam int FRAC_SH    = SIM_W - 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 5;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [SIM_W-1:0] HALF_Q16  = 16'h8000;
  localparam logic [SIM_W-1:0] SIM_MAX   = 16'hFFFF;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
  localparam logic             REG_EPS   = 1'b0;

  typedef struct packed {
    logic prod_load;
    logic acc_en;
    logic sq_load;
    logic sq_step;
    logic mul_en;
    logic den_en;
    logic tsum_en;
    logic num_en;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

[rtl/csu_isqrt.sv]
`timescale 1ns / 1ps
// Bit-serial floor integer square root, one result bit per step.
module csu_isqrt (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [csu_pkg::NORM_W-1:0]  x,
  output logic [csu_pkg::ROOT_W-1:0]  root
);

  localparam int XW   = 2 * csu_pkg::ROOT_W;
  localparam int REMW = csu_pkg::ROOT_W + 1;
  localparam int TRW  = REMW + 2;

  logic [XW-1:0]              x_r;
  logic [REMW-1:0]            rem_r;
  logic [csu_pkg::ROOT_W-1:0] root_r;
  logic [TRW-1:0]             rem_sh;
  logic [TRW-1:0]             trial;
  logic [TRW-1:0]             diff;
  logic                       ge;

  assign rem_sh = {rem_r, x_r[XW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= XW'(x);
      rem_r  <= '0;
      root_r <= '0;
    end else if (step) begin
      x_r    <= {x_r[XW-3:0], 2'b00};
      rem_r  <= ge ? diff[REMW-1:0] : rem_sh[REMW-1:0];
      root_r <= {root_r[csu_pkg::ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;

endmodule

[rtl/csu_datapath.sv]
`timescale 1ns / 1ps
// Datapath: products, saturating sums, square roots, denominator, divider and result register.
module csu_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csu_pkg::cmd_t                     cmd,
  output csu_pkg::sts_t                     sts,
  input  logic [csu_pkg::EPS_W-1:0]         eps,
  input  logic signed [csu_pkg::ELEM_W-1:0] a_elem,
  input  logic signed [csu_pkg::ELEM_W-1:0] b_elem,
  input  logic                              last,
  output logic [csu_pkg::SIM_W-1:0]         similarity,
  output logic                              div_zero
);

  localparam int DW = csu_pkg::DOT_W;
  localparam int NW = csu_pkg::NORM_W;

  logic signed [csu_pkg::PROD_W-1:0] pab_r;
  logic [csu_pkg::SQ_W-1:0]          paa_r;
  logic [csu_pkg::SQ_W-1:0]          pbb_r;
  logic                              last_r;
  logic signed [csu_pkg::PROD_W-1:0] pab;
  logic signed [csu_pkg::PROD_W-1:0] paa;
  logic signed [csu_pkg::PROD_W-1:0] pbb;

  logic signed [DW-1:0] dot_r;
  logic [NW-1:0]        na_r;
  logic [NW-1:0]        nb_r;
  logic signed [DW:0]   dot_sum;
  logic [NW:0]          na_sum;
  logic [NW:0]          nb_sum;
  logic signed [DW-1:0] dot_nxt;
  logic [NW-1:0]        na_nxt;
  logic [NW-1:0]        nb_nxt;

  logic [csu_pkg::ROOT_W-1:0]      root_a;
  logic [csu_pkg::ROOT_W-1:0]      root_b;
  logic [csu_pkg::RPROD_W-1:0]     rprod_r;
  logic [csu_pkg::DEN_W-1:0]       den_r;
  logic signed [csu_pkg::T_W-1:0]  t_r;
  logic                            dz_r;
  logic                            tpos_r;
  logic [csu_pkg::NUM_W-1:0]       rem_r;
  logic [csu_pkg::DSH_W-1:0]       dsh_r;
  logic [csu_pkg::QUO_W-1:0]       q_r;
  logic                            q_ge;
  logic [csu_pkg::SIM_W-1:0]       sim_nxt;
  logic [csu_pkg::SIM_W-1:0]       sim_r;
  logic                            dzo_r;

  assign pab = csu_pkg::PROD_W'(a_elem) * csu_pkg::PROD_W'(b_elem);
  assign paa = csu_pkg::PROD_W'(a_elem) * csu_pkg::PROD_W'(a_elem);
  assign pbb = csu_pkg::PROD_W'(b_elem) * csu_pkg::PROD_W'(b_elem);

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      pab_r  <= pab;
      paa_r  <= paa[csu_pkg::SQ_W-1:0];
      pbb_r  <= pbb[csu_pkg::SQ_W-1:0];
      last_r <= last;
    end
  end

  assign sts.last = last_r;

  assign dot_sum = {dot_r[DW-1], dot_r} + (DW+1)'(pab_r);
  assign na_sum  = {1'b0, na_r} + (NW+1)'(paa_r);
  assign nb_sum  = {1'b0, nb_r} + (NW+1)'(pbb_r);

  always_comb begin
    if (dot_sum[DW] != dot_sum[DW-1]) begin
      dot_nxt = dot_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      dot_nxt = dot_sum[DW-1:0];
    end
    na_nxt = na_sum[NW] ? {NW{1'b1}} : na_sum[NW-1:0];
    nb_nxt = nb_sum[NW] ? {NW{1'b1}} : nb_sum[NW-1:0];
  end

  csu_isqrt u_sqrt_a (
    .clk  (clk),
    .load (cmd.sq_load),
    .step (cmd.sq_step),
    .x    (na_r),
    .root (root_a)
  );

  csu_isqrt u_sqrt_b (
    .clk  (clk),
    .load (cmd.sq_load),
    .step (cmd.sq_step),
    .x    (nb_r),
    .root (root_b)
  );

  assign q_ge = ({1'b0, dsh_r} <= rem_r);

  always_comb begin
    if (dz_r) begin
      sim_nxt = csu_pkg::HALF_Q16;
    end else if (!tpos_r) begin
      sim_nxt = '0;
    end else if (q_r[csu_pkg::QUO_W-1]) begin
      sim_nxt = csu_pkg::SIM_MAX;
    end else begin
      sim_nxt = q_r[csu_pkg::SIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      sim_r <= '0;
      dzo_r <= 1'b0;
    end else if (cmd.out_load) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      sim_r <= sim_nxt;
      dzo_r <= dz_r;
    end else if (cmd.acc_en) begin
      dot_r <= dot_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
    end
    if (cmd.mul_en) begin
      rprod_r <= csu_pkg::RPROD_W'(root_a) * csu_pkg::RPROD_W'(root_b);
    end
    if (cmd.den_en) begin
      den_r <= csu_pkg::DEN_W'(rprod_r) + csu_pkg::DEN_W'(eps);
    end
    if (cmd.tsum_en) begin
      t_r  <= csu_pkg::T_W'(dot_r) + $signed({1'b0, den_r});
      dz_r <= (den_r == '0);
    end
    if (cmd.num_en) begin
      rem_r  <= csu_pkg::NUM_W'({t_r, {csu_pkg::FRAC_SH{1'b0}}})
              + csu_pkg::NUM_W'(den_r[csu_pkg::DEN_W-1:1]);
      dsh_r  <= {den_r, {csu_pkg::SIM_W{1'b0}}};
      q_r    <= '0;
      tpos_r <= !t_r[csu_pkg::T_W-1] && (t_r != '0);
    end else if (cmd.div_step) begin
      rem_r <= q_ge ? (rem_r - {1'b0, dsh_r}) : rem_r;
      dsh_r <= {1'b0, dsh_r[csu_pkg::DSH_W-1:1]};
      q_r   <= {q_r[csu_pkg::QUO_W-2:0], q_ge};
    end
  end

  assign similarity = sim_r;
  assign div_zero   = dzo_r;

endmodule

[rtl/csu_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine that sequences accumulation and the final square root and divide.
module csu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  csu_pkg::sts_t sts,
  output csu_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_SQ_LOAD,
    S_SQRT,
    S_MUL,
    S_DEN,
    S_TSUM,
    S_NUM,
    S_DIV,
    S_DONE
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [csu_pkg::CNT_W-1:0]   cnt_r;
  logic [csu_pkg::CNT_W-1:0]   cnt_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_free;

  assign out_free = !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.prod_load = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = sts.last ? S_SQ_LOAD : S_IDLE;
      end
      S_SQ_LOAD: begin
        cmd.sq_load = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == csu_pkg::CNT_W'(csu_pkg::SQRT_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_DEN;
      end
      S_DEN: begin
        cmd.den_en = 1'b1;
        state_nxt  = S_TSUM;
      end
      S_TSUM: begin
        cmd.tsum_en = 1'b1;
        state_nxt   = S_NUM;
      end
      S_NUM: begin
        cmd.num_en = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == csu_pkg::CNT_W'(csu_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ACC))
    else $error("accepted request did not move to accumulation");

  a_plain_item_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && !sts.last) |=> (state_r == S_IDLE))
    else $error("request without last did not return to idle");

  a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (cnt_r < csu_pkg::CNT_W'(csu_pkg::SQRT_STEPS)))
    else $error("square root step count out of range");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < csu_pkg::CNT_W'(csu_pkg::DIV_STEPS)))
    else $error("divide step count out of range");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

[rtl/cosine_similarity_unit.sv]
`timescale 1ns / 1ps
// Top level of the cosine similarity unit: register port, controller and datapath.
//
// Each request carries one element pair (a_elem, b_elem) in signed Q1.15 and a last flag.
// A request without last forms the three products and then adds them into the saturating
// dot and norm sums. A request with last, after the same element work and before the next
// request is taken, loads the two bit-serial square root units, runs 21 square root steps
// (one root bit per cycle), forms in turn the root product, the eps add, the dot sum add and
// the rounding offset, runs 17 restoring divide steps (one quotient bit per cycle), and loads
// the result register once the output is free. The result register holds a finished similarity
// while the next vector streams in; a new result waits only if the previous one is still
// stalled. Similarity is 0.5 + 0.5 * cosine in unsigned Q0.16, rounded and saturated;
// div_zero flags a zero denominator, with similarity 0.5. Register eps (byte address 0,
// reset 1) must be written only while the unit is idle.
module cosine_similarity_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [csu_pkg::ELEM_W-1:0]  in_a_elem,
  input  logic signed [csu_pkg::ELEM_W-1:0]  in_b_elem,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [csu_pkg::SIM_W-1:0]          out_similarity,
  output logic                               out_div_zero,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csu_pkg::ADDR_W-1:0]         paddr,
  input  logic [csu_pkg::DATA_W-1:0]         pwdata,
  output logic [csu_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [csu_pkg::EPS_W-1:0] eps_r;
  logic                      reg_idx;
  csu_pkg::cmd_t             cmd;
  csu_pkg::sts_t             sts;

  assign reg_idx = paddr[csu_pkg::ADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= csu_pkg::EPS_RESET;
    end else if (psel && penable && pwrite && (reg_idx == csu_pkg::REG_EPS)) begin
      eps_r <= pwdata[csu_pkg::EPS_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      csu_pkg::REG_EPS: prdata = csu_pkg::DATA_W'(eps_r);
      default:          prdata = '0;
    endcase
  end

  csu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  csu_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .eps        (eps_r),
    .a_elem     (in_a_elem),
    .b_elem     (in_b_elem),
    .last       (in_last),
    .similarity (out_similarity),
    .div_zero   (out_div_zero)
  );

endmodule
